// File: src/sjf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shortest-job-first scheduler.
// No dependencies.
package sjf_pkg;

    localparam int ID_W    = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 21;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
    } entry_t;

endpackage

// File: src/sjf_nonpreemptive_scheduler.sv
`timescale 1ns / 1ps
// Non-preemptive shortest-job-first scheduler: entry table memory, scan unit and
// result register. Depends on sjf_pkg.
//
// Entries are loaded one beat per cycle into a table memory with one write port
// and one read port; a beat with s_tlast set closes the run (an entry that finds
// the table full is dropped). The block then emits one result beat per loaded
// entry in schedule order and takes no input until the last result has been
// registered. Each pick scans the loaded entries through the memory's single
// read port, one entry per cycle. The next run starts again at time 0. Times
// saturate at 2^21 - 1.
module sjf_nonpreemptive_scheduler
    import sjf_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // process_id[7:0], arrival_time[23:8], burst_time[39:24]
    input  logic        s_tlast,   // last_entry

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // sched_id[7:0], start_time[28:8], finish_time[49:29], 0
    output logic        m_tuser,   // idle_before
    output logic        m_tlast    // last_result
);

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    entry_t mem [MAX_PROCESSES];
    entry_t rd_entry_reg;
    logic   wr_en;
    entry_t wr_entry;

    logic [MAX_PROCESSES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next, cnt_after;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [TIME_W-1:0]        time_reg, time_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             iss_done_reg, iss_done_next;
    logic             scan_last;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             cmp_last_reg, cmp_last_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             rd_ok_reg, rd_ok_next;

    logic             a_found_reg, a_found_next;
    logic [IDX_W-1:0] a_idx_reg, a_idx_next;
    entry_t           a_ent_reg, a_ent_next;
    logic             e_found_reg, e_found_next;
    logic [IDX_W-1:0] e_idx_reg, e_idx_next;
    entry_t           e_ent_reg, e_ent_next;

    logic             arrived, a_better, e_better;
    logic             pick_idle;
    logic [IDX_W-1:0] pick_idx;
    entry_t           pick_ent;
    logic [TIME_W-1:0] start_time, finish_time;
    logic [TIME_W:0]   finish_sum;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        s_fire, emit_load;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign wr_entry.id    = s_tdata[7:0];
    assign wr_entry.arr   = s_tdata[23:8];
    assign wr_entry.burst = s_tdata[39:24];
    assign wr_en          = s_fire && (cnt_reg < CNT_MAX);
    assign cnt_after      = wr_en ? cnt_reg + 1'b1 : cnt_reg;

    assign scan_last = (CNT_W'(scan_idx_reg) == cnt_reg - 1'b1);

    assign arrived  = ({{(TIME_W - ARR_W){1'b0}}, rd_entry_reg.arr} <= time_reg);
    assign a_better = !a_found_reg || (rd_entry_reg.burst < a_ent_reg.burst) ||
                      ((rd_entry_reg.burst == a_ent_reg.burst) &&
                       (rd_entry_reg.arr < a_ent_reg.arr));
    assign e_better = !e_found_reg || (rd_entry_reg.arr < e_ent_reg.arr);

    assign pick_idle   = !a_found_reg;
    assign pick_idx    = pick_idle ? e_idx_reg : a_idx_reg;
    assign pick_ent    = pick_idle ? e_ent_reg : a_ent_reg;
    assign start_time  = pick_idle ? {{(TIME_W - ARR_W){1'b0}}, pick_ent.arr} : time_reg;
    assign finish_sum  = {1'b0, start_time} + (TIME_W + 1)'(pick_ent.burst);
    assign finish_time = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];
    assign emit_load   = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[IDX_W-1:0]] <= wr_entry;
        end
        rd_entry_reg <= mem[scan_idx_reg];
    end

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        time_next     = time_reg;
        scan_idx_next = scan_idx_reg;
        iss_done_next = iss_done_reg;
        cmp_vld_next  = 1'b0;
        cmp_last_next = 1'b0;
        cmp_idx_next  = scan_idx_reg;
        rd_ok_next    = valid_reg[scan_idx_reg];
        a_found_next  = a_found_reg;
        a_idx_next    = a_idx_reg;
        a_ent_next    = a_ent_reg;
        e_found_next  = e_found_reg;
        e_idx_next    = e_idx_reg;
        e_ent_next    = e_ent_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_LOAD: begin
                if (wr_en) begin
                    valid_next[cnt_reg[IDX_W-1:0]] = 1'b1;
                    cnt_next = cnt_after;
                end
                if (s_fire && s_tlast && (cnt_after != '0)) begin
                    state_next    = ST_SCAN;
                    rem_next      = cnt_after;
                    time_next     = '0;
                    scan_idx_next = '0;
                    iss_done_next = 1'b0;
                    a_found_next  = 1'b0;
                    e_found_next  = 1'b0;
                end
            end
            ST_SCAN: begin
                if (!iss_done_reg) begin
                    cmp_vld_next  = 1'b1;
                    cmp_last_next = scan_last;
                    if (scan_last) begin
                        iss_done_next = 1'b1;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (cmp_vld_reg && rd_ok_reg) begin
                    if (arrived && a_better) begin
                        a_found_next = 1'b1;
                        a_idx_next   = cmp_idx_reg;
                        a_ent_next   = rd_entry_reg;
                    end
                    if (e_better) begin
                        e_found_next = 1'b1;
                        e_idx_next   = cmp_idx_reg;
                        e_ent_next   = rd_entry_reg;
                    end
                end
                if (cmp_vld_reg && cmp_last_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, finish_time, start_time, pick_ent.id};
                    m_tuser_next  = pick_idle;
                    m_tlast_next  = (rem_reg == CNT_W'(1));
                    valid_next[pick_idx] = 1'b0;
                    time_next     = finish_time;
                    rem_next      = rem_reg - 1'b1;
                    scan_idx_next = '0;
                    iss_done_next = 1'b0;
                    a_found_next  = 1'b0;
                    e_found_next  = 1'b0;
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        valid_next = '0;
                        time_next  = '0;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            rem_reg      <= '0;
            time_reg     <= '0;
            scan_idx_reg <= '0;
            iss_done_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            cmp_last_reg <= 1'b0;
            a_found_reg  <= 1'b0;
            e_found_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            rem_reg      <= rem_next;
            time_reg     <= time_next;
            scan_idx_reg <= scan_idx_next;
            iss_done_reg <= iss_done_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_last_reg <= cmp_last_next;
            a_found_reg  <= a_found_next;
            e_found_reg  <= e_found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        rd_ok_reg   <= rd_ok_next;
        a_idx_reg   <= a_idx_next;
        a_ent_reg   <= a_ent_next;
        e_idx_reg   <= e_idx_next;
        e_ent_reg   <= e_ent_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> ($countones(valid_reg) == int'(cnt_reg)))
        else $error("valid bits disagree with fill count while loading");

    a_scan_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> ($countones(valid_reg) == int'(rem_reg)))
        else $error("valid bits disagree with remaining entries");

    a_emit_has_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (a_found_reg || e_found_reg))
        else $error("emit without a candidate");

    a_run_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_load && (rem_reg == CNT_W'(1))) |=>
            ((cnt_reg == '0) && (valid_reg == '0) && m_tlast_reg))
        else $error("table not cleared after final result");

endmodule

// File: dv/tb_sjf_nonpreemptive_scheduler.sv
`timescale 1ns / 1ps
// Self-checking testbench for the shortest-job-first scheduler: streams process
// tables in, predicts each schedule and checks every result beat. Depends on sjf_pkg.
module tb_sjf_nonpreemptive_scheduler;
    import sjf_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int ITEM_TARGET = 330;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 320;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] finish;
        logic              idle;
        logic              last;
    } slot_result_t;

    class sjf_scoreboard;
        entry_t       loaded[$];
        slot_result_t schedule_q[$];
        int           failures;

        function new();
            failures = 0;
        endfunction

        // Load one entry; on the closing beat build the whole schedule.
        function void note_entry(entry_t e, bit closing);
            bit                used[$];
            int                best;
            bit                idle;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] now;
            slot_result_t      r;
            if (loaded.size() < TABLE_DEPTH)
                loaded.push_back(e);
            if (!closing)
                return;
            foreach (loaded[i]) used.push_back(1'b0);
            now = '0;
            for (int n = 0; n < loaded.size(); n++) begin
                best = -1;
                foreach (loaded[i]) begin
                    if (used[i] || TIME_W'(loaded[i].arr) > now)
                        continue;
                    if (best < 0 || loaded[i].burst < loaded[best].burst ||
                        (loaded[i].burst == loaded[best].burst &&
                         loaded[i].arr < loaded[best].arr))
                        best = i;
                end
                idle = 1'b0;
                if (best < 0) begin
                    foreach (loaded[i]) begin
                        if (used[i])
                            continue;
                        if (best < 0 || loaded[i].arr < loaded[best].arr)
                            best = i;
                    end
                    idle = 1'b1;
                    now = TIME_W'(loaded[best].arr);
                end
                sum = {1'b0, now} + (TIME_W + 1)'(loaded[best].burst);
                r.id = loaded[best].id;
                r.start = now;
                r.finish = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
                r.idle = idle;
                r.last = (n == loaded.size() - 1);
                now = r.finish;
                used[best] = 1'b1;
                schedule_q.push_back(r);
            end
            loaded.delete();
        endfunction

        function void check_result(logic [55:0] data, logic user, logic lst);
            slot_result_t exp_r;
            if (schedule_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: data %h idle %b last %b",
                             data, user, lst);
                return;
            end
            exp_r = schedule_q.pop_front();
            if (data[7:0] !== exp_r.id || data[28:8] !== exp_r.start ||
                data[49:29] !== exp_r.finish || user !== exp_r.idle ||
                lst !== exp_r.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("result mismatch: exp id %0d start %0d finish %0d idle %b last %b",
                             exp_r.id, exp_r.start, exp_r.finish, exp_r.idle, exp_r.last);
                    $display("                 got id %0d start %0d finish %0d idle %b last %b",
                             data[7:0], data[28:8], data[49:29], user, lst);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sjf_scoreboard sb = new();
    int            items_sent;
    int            cycles;
    int unsigned   send_quiet;
    int unsigned   recv_quiet;

    sjf_nonpreemptive_scheduler #(.MAX_PROCESSES(TABLE_DEPTH)) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly random waits, with occasional stretches of back-to-back beats.
    function automatic int unsigned draw_wait(ref int unsigned quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    task automatic send_entry(input entry_t e, input bit closing);
        int unsigned gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {e.burst, e.arr, e.id};
        s_tlast <= closing;
        do @(posedge aclk); while (!s_tready);
        sb.note_entry(e, closing);
        items_sent++;
    endtask

    task automatic send_fields(input int id, input int arr, input int burst,
                               input bit closing);
        entry_t e;
        e.id = ID_W'(id);
        e.arr = ARR_W'(arr);
        e.burst = BURST_W'(burst);
        send_entry(e, closing);
    endtask

    // Drop valid and hold off until every expected result has been seen.
    task automatic wait_schedule_done();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.schedule_q.size() != 0);
    endtask

    task automatic send_random_run();
        int          len;
        int unsigned shape;
        int unsigned arr_hi;
        int unsigned burst_hi;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                          : $urandom_range(1, TABLE_DEPTH);
        shape = $urandom_range(0, 3);
        case (shape)
            0: begin
                arr_hi = 60;
                burst_hi = 12;
            end
            1: begin
                arr_hi = 65535;
                burst_hi = 40;
            end
            2: begin
                arr_hi = 400;
                burst_hi = 65535;
            end
            default: begin
                arr_hi = 65535;
                burst_hi = 65535;
            end
        endcase
        for (int i = 0; i < len; i++)
            send_fields($urandom_range(0, 255), $urandom_range(0, arr_hi),
                        $urandom_range(0, burst_hi), i == len - 1);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        items_sent = 0;
        send_quiet = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // single entry at the field maxima, CPU idles until it arrives
        send_fields(255, 65535, 65535, 1'b1);
        // first pick by arrival, then equal bursts resolved by earlier arrival
        send_fields(1, 5, 3, 1'b0);
        send_fields(2, 2, 3, 1'b0);
        send_fields(3, 0, 10, 1'b1);
        // idle with equal arrivals goes to load order; zero bursts
        send_fields(16, 100, 0, 1'b0);
        send_fields(17, 100, 0, 1'b1);
        // overfill the table: the closing beat itself is dropped
        for (int i = 0; i <= TABLE_DEPTH; i++)
            send_fields(32 + i, $urandom_range(0, 200), $urandom_range(0, 50),
                        i == TABLE_DEPTH);

        // hold off until the whole schedule has drained
        wait_schedule_done();

        while (items_sent < ITEM_TARGET) begin
            send_random_run();
            if ($urandom_range(0, 7) == 0)
                wait_schedule_done();
        end
        s_tlast <= 1'b0;

        wait_schedule_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.schedule_q.size() != 0)
            sb.failures += sb.schedule_q.size();
        if (sb.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        m_tready <= 1'b0;
        recv_quiet = 0;
        repeat (6) @(posedge aclk);
        forever begin
            int unsigned stall;
            stall = draw_wait(recv_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
src/sjf_pkg.sv
src/sjf_nonpreemptive_scheduler.sv
dv/tb_sjf_nonpreemptive_scheduler.sv
